/* rtl/jd2cal_pkg.sv */
// ----------------------------------------------------------------------------
// jd2cal_pkg
// Constants, the stage record and the month offset table shared by the
// Julian date to calendar converter.
// ----------------------------------------------------------------------------
package jd2cal_pkg;

    // fixed-point formats
    localparam int FRACTION_BITS        = 40;
    localparam int SECOND_FRACTION_BITS = 24;

    // first day number that takes the Gregorian century correction
    localparam int GREGORIAN_START = 2299161;

    // alpha = floor((4z - ALPHA_BIAS) / ALPHA_DIV)
    localparam int ALPHA_BIAS  = 7468865;
    localparam int ALPHA_DIV   = 146097;
    localparam int ALPHA_SHIFT = 29;
    localparam int ALPHA_RECIP = (1 << ALPHA_SHIFT) / ALPHA_DIV;

    localparam int CAL_OFFSET = 1524;

    // c = floor((100b - 12210) / 36525) = floor((4b - C_BIAS) / C_DIV)
    localparam int C_BIAS  = 489;
    localparam int C_DIV   = 1461;
    localparam int C_SHIFT = 30;
    localparam int C_RECIP = (1 << C_SHIFT) / C_DIV;

    // e = floor(E_NUM * (b - d) / E_DIV)
    localparam int E_NUM   = 10000;
    localparam int E_DIV   = 306001;
    localparam int E_SHIFT = 24;
    localparam int E_RECIP = E_NUM * ((1 << E_SHIFT) / E_DIV);

    localparam int YEAR_BASE_LATE  = 4716;
    localparam int YEAR_BASE_EARLY = 4715;

    localparam int NUM_STAGES = 12;

    localparam logic [FRACTION_BITS-1:0] HALF_DAY = {1'b1, {(FRACTION_BITS-1){1'b0}}};

    typedef struct packed {
        logic [27:0]              z;
        logic [FRACTION_BITS-1:0] fr;
        logic                     greg;
        logic [28:0]              xa;
        logic [19:0]              q;
        logic [11:0]              alpha;
        logic [27:0]              b;
        logic [29:0]              y;
        logic [19:0]              c;
        logic [8:0]               bd;
        logic [3:0]               e;
        logic [4:0]               hour;
        logic [5:0]               minute;
        logic [5:0]               secs;
        logic [FRACTION_BITS-1:0] tfrac;
        logic [19:0]              year;
        logic [3:0]               month;
        logic [4:0]               day;
        logic [29:0]              sec_fixed;
    } t_stage;

    // floor(306001 * e / 10000), days before the start of month index e
    function automatic logic [8:0] month_start_off(input logic [3:0] e);
        logic [8:0] off;
        case (e)
            4'd1:    off = 9'd30;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd91;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd183;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd244;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd336;
            4'd12:   off = 9'd367;
            4'd13:   off = 9'd397;
            4'd14:   off = 9'd428;
            4'd15:   off = 9'd459;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

/* rtl/julian_day_to_calendar_top.sv */
// ----------------------------------------------------------------------------
// julian_day_to_calendar_top
// Julian date (day number plus Q0.40 day fraction) to civil calendar date and
// time of day, fully pipelined.
//
// Usage: drive i_whole_day / i_day_fraction and raise start; a beat is taken
// at each rising edge with start high and busy low. busy is low whenever the
// block is out of reset, so a new beat can be taken every cycle.
// The result appears on the o_ ports for one cycle with o_strobe high, in
// input order.
// Throughput: one conversion per cycle; the twelve register stages hold the
// reciprocal divisions for alpha, the century count c and the month index e,
// each split into estimate and correction steps.
// Reset: synchronous, active low; clears all stage valid bits so no stray
// strobe follows reset, and busy is high while reset is held.
// The receiver cannot stall: every result is presented exactly once.
// ----------------------------------------------------------------------------
module julian_day_to_calendar_top
    import jd2cal_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [26:0] i_whole_day,
    input  logic [39:0] i_day_fraction,
    output logic        o_strobe,
    output logic [19:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [29:0] o_second_fixed
);

    localparam int FB  = FRACTION_BITS;
    localparam int SFB = SECOND_FRACTION_BITS;

    t_stage                r_p [NUM_STAGES];
    t_stage                n_p [NUM_STAGES];
    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES-1:0] n_v;

    // pipeline never stalls, only reset holds off input
    assign busy = ~i_rst_n;

    assign n_v = {r_v[NUM_STAGES-2:0], start & ~busy};

    always_comb begin
        logic [FB+39:0]  w_fx;
        logic [FB-1:0]   w_f;
        logic [FB:0]     w_fsum;
        logic [29:0]     w_z4;
        logic [40:0]     w_qa_p;
        logic [29:0]     w_ra;
        logic [49:0]     w_qc_p;
        logic [29:0]     w_rc;
        logic [30:0]     w_d_p;
        logic [28:0]     w_bd_full;
        logic [28:0]     w_e_p;
        logic [22:0]     w_re;
        logic [FB+4:0]   w_t1;
        logic [FB+5:0]   w_t2;
        logic [FB+5:0]   w_t3;
        logic [8:0]      w_day_full;
        logic [FB+SFB-1:0] w_sx;
        logic [SFB+35:0] w_sec;

        // stage 0: add the half day, carry into the day number
        w_fx   = {{FB{1'b0}}, i_day_fraction};
        w_f    = w_fx[FB-1:0];
        w_fsum = {1'b0, w_f} + {1'b0, HALF_DAY};
        n_p[0] = '0;
        n_p[0].fr = w_fsum[FB-1:0];
        n_p[0].z  = {1'b0, i_whole_day} + {27'b0, w_fsum[FB]};

        // stage 1: gregorian test and alpha numerator; hours
        n_p[1] = r_p[0];
        n_p[1].greg = (r_p[0].z >= 28'(GREGORIAN_START));
        w_z4 = {r_p[0].z, 2'b00} - 30'(ALPHA_BIAS);
        n_p[1].xa = n_p[1].greg ? w_z4[28:0] : 29'd0;
        w_t1 = (FB+5)'(r_p[0].fr) * (FB+5)'(24);
        n_p[1].hour  = w_t1[FB+4:FB];
        n_p[1].tfrac = w_t1[FB-1:0];

        // stage 2: alpha estimate; minutes
        n_p[2] = r_p[1];
        w_qa_p = {12'b0, r_p[1].xa} * 41'(ALPHA_RECIP);
        n_p[2].q = {8'b0, w_qa_p[40:29]};
        w_t2 = (FB+6)'(r_p[1].tfrac) * (FB+6)'(60);
        n_p[2].minute = w_t2[FB+5:FB];
        n_p[2].tfrac  = w_t2[FB-1:0];

        // stage 3: alpha correction; seconds
        n_p[3] = r_p[2];
        w_ra = {1'b0, r_p[2].xa} - (30'(r_p[2].q[11:0]) * 30'(ALPHA_DIV));
        n_p[3].alpha = r_p[2].q[11:0] + {11'b0, (w_ra >= 30'(ALPHA_DIV))};
        w_t3 = (FB+6)'(r_p[2].tfrac) * (FB+6)'(60);
        n_p[3].secs  = w_t3[FB+5:FB];
        n_p[3].tfrac = w_t3[FB-1:0];

        // stage 4: b
        n_p[4] = r_p[3];
        if (r_p[3].greg) begin
            n_p[4].b = r_p[3].z + 28'(r_p[3].alpha) - 28'(r_p[3].alpha[11:2])
                     + 28'(CAL_OFFSET + 1);
        end else begin
            n_p[4].b = r_p[3].z + 28'(CAL_OFFSET);
        end

        // stage 5: c numerator
        n_p[5] = r_p[4];
        n_p[5].y = {r_p[4].b, 2'b00} - 30'(C_BIAS);

        // stage 6: c estimate
        n_p[6] = r_p[5];
        w_qc_p = {20'b0, r_p[5].y} * 50'(C_RECIP);
        n_p[6].q = w_qc_p[49:30];

        // stage 7: c correction
        n_p[7] = r_p[6];
        w_rc = r_p[6].y - (30'(r_p[6].q) * 30'(C_DIV));
        n_p[7].c = r_p[6].q + {19'b0, (w_rc >= 30'(C_DIV))};

        // stage 8: days into the year, b - floor(1461c/4)
        n_p[8] = r_p[7];
        w_d_p = {11'b0, r_p[7].c} * 31'(C_DIV);
        w_bd_full = {1'b0, r_p[7].b} - w_d_p[30:2];
        n_p[8].bd = w_bd_full[8:0];

        // stage 9: month index estimate
        n_p[9] = r_p[8];
        w_e_p = {20'b0, r_p[8].bd} * 29'(E_RECIP);
        n_p[9].e = w_e_p[27:24];

        // stage 10: month index correction
        n_p[10] = r_p[9];
        w_re = (23'(r_p[9].bd) * 23'(E_NUM)) - (23'(r_p[9].e) * 23'(E_DIV));
        n_p[10].e = r_p[9].e + {3'b0, (w_re >= 23'(E_DIV))};

        // stage 11: calendar fields and packed seconds
        n_p[11] = r_p[10];
        w_day_full = r_p[10].bd - month_start_off(r_p[10].e);
        n_p[11].day = w_day_full[4:0];
        n_p[11].month = (r_p[10].e < 4'd14) ? r_p[10].e - 4'd1 : r_p[10].e - 4'd13;
        n_p[11].year = (n_p[11].month > 4'd2) ? r_p[10].c - 20'(YEAR_BASE_LATE)
                                              : r_p[10].c - 20'(YEAR_BASE_EARLY);
        w_sx  = {r_p[10].tfrac, {SFB{1'b0}}};
        w_sec = {30'b0, r_p[10].secs, w_sx[FB+SFB-1:FB]};
        n_p[11].sec_fixed = w_sec[29:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_strobe       = r_v[NUM_STAGES-1];
    assign o_year         = r_p[NUM_STAGES-1].year;
    assign o_month        = r_p[NUM_STAGES-1].month;
    assign o_day_of_month = r_p[NUM_STAGES-1].day;
    assign o_hour         = r_p[NUM_STAGES-1].hour;
    assign o_minute       = r_p[NUM_STAGES-1].minute;
    assign o_second_fixed = r_p[NUM_STAGES-1].sec_fixed;

    // every result beat traces back to an accepted beat
    a_strobe_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, NUM_STAGES))
        else $error("result beat without a matching input beat");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_month >= 4'd1) && (o_month <= 4'd12))
        else $error("month out of range");

    a_day_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_day_of_month != 5'd0))
        else $error("day of month is zero, month index correction slipped");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_hour <= 5'd23) && (o_minute <= 6'd59))
        else $error("time of day out of range");

endmodule
